// ===== src/bmpdec_pkg.sv =====
// Shared types and constants for the 24-bit bitmap stream decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bmpdec_pkg;

	localparam int MAX_DIM_DEFAULT     = 8192;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [7:0] SIG_B = 8'h42;
	localparam logic [7:0] SIG_M = 8'h4D;

	localparam int FILE_HDR_LEN = 14;
	localparam int CORE_HDR_LEN = 12;
	localparam int INFO_HDR_LEN = 40;
	localparam int RGB24_DEPTH  = 24;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_SIGNATURE = 3'd1,
		ST_INFO_SIZE = 3'd2,
		ST_FORMAT    = 3'd3,
		ST_TRUNCATED = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		kind_t       item_kind;
		status_t     reject_status;
		logic [13:0] image_width;
		logic [13:0] image_height;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [12:0] pixel_x;
		logic [12:0] pixel_y;
		logic        image_done;
	} out_item_t;

	// Work token between front and back
	typedef enum logic [1:0] {
		TOK_ITEM  = 2'd0,
		TOK_BLUE  = 2'd1,
		TOK_GREEN = 2'd2,
		TOK_RED   = 2'd3
	} tok_op_t;

	typedef struct packed {
		tok_op_t    op;
		logic [7:0] data_byte;
		out_item_t  item;
	} token_t;

endpackage

`default_nettype wire

// ===== src/bmpdec_front.sv =====
// Front end: header parser and pixel position tracker, one byte per cycle while accept is high.
// Emits at most one work token per byte. Depends on bmpdec_pkg.
`default_nettype none

module bmpdec_front import bmpdec_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t feed,
	output logic          tok_valid,
	output token_t        tok
);

	localparam int CNT_W = (MAX_DIM < 2) ? 1 : $clog2(MAX_DIM + 1);

	typedef enum logic [2:0] {
		PH_FILE  = 3'd0,
		PH_INFO  = 3'd1,
		PH_PIXEL = 3'd2,
		PH_PAD   = 3'd3,
		PH_IDLE  = 3'd4
	} phase_t;

	phase_t             phase_q, phase_nx;
	logic [5:0]         cnt_q, cnt_nx, cnt_inc;
	logic               sig_bad_q, sig_bad_nx;
	logic [31:0]        size_q, size_nx;
	logic [31:0]        raw_w_q, raw_w_nx;
	logic [31:0]        raw_h_q, raw_h_nx;
	logic [15:0]        depth_q, depth_nx;
	logic               comp_nz_q, comp_nz_nx;
	logic [CNT_W-1:0]   img_w_q, img_w_nx;
	logic [CNT_W-1:0]   img_h_q, img_h_nx;
	logic [CNT_W-1:0]   col_q, col_nx;
	logic [CNT_W-1:0]   row_q, row_nx;
	logic [1:0]         bip_q, bip_nx;
	logic [1:0]         pad_q, pad_nx;

	logic               core;
	logic [31:0]        w_val, h_val;
	logic               fmt_ok;
	logic               last_col, done;

	function automatic logic dim_ok(input logic [31:0] raw, input logic is_core);
		logic [31:0] v;
		logic        neg;
		v   = is_core ? {16'd0, raw[15:0]} : raw;
		neg = is_core ? raw[15] : raw[31];
		return !neg && (v != 32'd0) && (v <= 32'(MAX_DIM));
	endfunction

	always_comb begin
		phase_nx   = phase_q;
		cnt_nx     = cnt_q;
		sig_bad_nx = sig_bad_q;
		size_nx    = size_q;
		raw_w_nx   = raw_w_q;
		raw_h_nx   = raw_h_q;
		depth_nx   = depth_q;
		comp_nz_nx = comp_nz_q;
		img_w_nx   = img_w_q;
		img_h_nx   = img_h_q;
		col_nx     = col_q;
		row_nx     = row_q;
		bip_nx     = bip_q;
		pad_nx     = pad_q;
		tok_valid  = 1'b0;
		tok        = '0;
		cnt_inc    = cnt_q + 6'd1;
		core       = (size_q == 32'(CORE_HDR_LEN));
		w_val      = 32'd0;
		h_val      = 32'd0;
		fmt_ok     = 1'b0;
		last_col   = (col_q + CNT_W'(1)) == img_w_q;
		done       = last_col && ((row_q + CNT_W'(1)) == img_h_q);

		if (accept) begin
			unique case (phase_q)
				PH_FILE: begin
					if (cnt_q == 6'd0 && feed.data_byte != SIG_B)
						sig_bad_nx = 1'b1;
					if (cnt_q == 6'd1 && feed.data_byte != SIG_M)
						sig_bad_nx = 1'b1;
					cnt_nx = cnt_inc;
					if (cnt_inc == 6'(FILE_HDR_LEN)) begin
						cnt_nx = 6'd0;
						if (sig_bad_nx) begin
							tok_valid                = 1'b1;
							tok.op                   = TOK_ITEM;
							tok.item.item_kind       = KIND_REJECT;
							tok.item.reject_status   = ST_SIGNATURE;
							phase_nx                 = PH_IDLE;
						end else begin
							phase_nx = PH_INFO;
						end
					end
				end
				PH_INFO: begin
					// capture little-endian fields by byte offset
					if (cnt_q < 6'd4) begin
						size_nx[{cnt_q[1:0], 3'b000} +: 8] = feed.data_byte;
					end else if (core) begin
						if (cnt_q < 6'd6)
							raw_w_nx[{cnt_q[0], 3'b000} +: 8] = feed.data_byte;
						else if (cnt_q < 6'd8)
							raw_h_nx[{cnt_q[0], 3'b000} +: 8] = feed.data_byte;
						else if (cnt_q == 6'd10 || cnt_q == 6'd11)
							depth_nx[{cnt_q[0], 3'b000} +: 8] = feed.data_byte;
					end else begin
						if (cnt_q < 6'd8)
							raw_w_nx[{cnt_q[1:0], 3'b000} +: 8] = feed.data_byte;
						else if (cnt_q < 6'd12)
							raw_h_nx[{cnt_q[1:0], 3'b000} +: 8] = feed.data_byte;
						else if (cnt_q == 6'd14 || cnt_q == 6'd15)
							depth_nx[{cnt_q[0], 3'b000} +: 8] = feed.data_byte;
						else if (cnt_q >= 6'd16 && cnt_q < 6'd20)
							comp_nz_nx = comp_nz_q || (feed.data_byte != 8'd0);
					end
					cnt_nx = cnt_inc;

					w_val  = core ? {16'd0, raw_w_nx[15:0]} : raw_w_nx;
					h_val  = core ? {16'd0, raw_h_nx[15:0]} : raw_h_nx;
					fmt_ok = dim_ok(raw_w_nx, core) && dim_ok(raw_h_nx, core)
						&& (depth_nx == 16'(RGB24_DEPTH))
						&& !(comp_nz_nx && !core);

					if (cnt_q == 6'd3 && size_nx != 32'(CORE_HDR_LEN)
							&& size_nx != 32'(INFO_HDR_LEN)) begin
						tok_valid              = 1'b1;
						tok.op                 = TOK_ITEM;
						tok.item.item_kind     = KIND_REJECT;
						tok.item.reject_status = ST_INFO_SIZE;
						phase_nx               = PH_IDLE;
					end else if (cnt_q >= 6'd4 && {26'd0, cnt_inc} == size_q) begin
						tok_valid = 1'b1;
						tok.op    = TOK_ITEM;
						if (!fmt_ok) begin
							tok.item.item_kind     = KIND_REJECT;
							tok.item.reject_status = ST_FORMAT;
							phase_nx               = PH_IDLE;
						end else begin
							tok.item.item_kind    = KIND_HEADER;
							tok.item.image_width  = 14'(w_val);
							tok.item.image_height = 14'(h_val);
							img_w_nx              = CNT_W'(w_val);
							img_h_nx              = CNT_W'(h_val);
							col_nx                = '0;
							row_nx                = '0;
							bip_nx                = 2'd0;
							phase_nx              = PH_PIXEL;
						end
					end
				end
				PH_PIXEL: begin
					tok_valid      = 1'b1;
					tok.data_byte  = feed.data_byte;
					if (bip_q == 2'd0) begin
						tok.op = TOK_BLUE;
						bip_nx = 2'd1;
					end else if (bip_q == 2'd1) begin
						tok.op = TOK_GREEN;
						bip_nx = 2'd2;
					end else begin
						tok.op              = TOK_RED;
						tok.item.item_kind  = KIND_PIXEL;
						tok.item.pixel_x    = 13'(col_q);
						tok.item.pixel_y    = 13'(row_q);
						tok.item.image_done = done;
						bip_nx              = 2'd0;
						if (done) begin
							phase_nx = PH_IDLE;
						end else if (last_col) begin
							col_nx = '0;
							row_nx = row_q + CNT_W'(1);
							pad_nx = 2'(img_w_q);
							if (pad_nx != 2'd0)
								phase_nx = PH_PAD;
						end else begin
							col_nx = col_q + CNT_W'(1);
						end
					end
				end
				PH_PAD: begin
					pad_nx = pad_q - 2'd1;
					if (pad_nx == 2'd0)
						phase_nx = PH_PIXEL;
				end
				default: begin
				end
			endcase

			if (feed.end_of_file) begin
				// an early end overrides whatever this byte produced, unless the file was already done or rejected
				if (phase_nx != PH_IDLE) begin
					tok_valid              = 1'b1;
					tok                    = '0;
					tok.op                 = TOK_ITEM;
					tok.item.item_kind     = KIND_REJECT;
					tok.item.reject_status = ST_TRUNCATED;
				end
				phase_nx   = PH_FILE;
				cnt_nx     = 6'd0;
				sig_bad_nx = 1'b0;
				size_nx    = 32'd0;
				raw_w_nx   = 32'd0;
				raw_h_nx   = 32'd0;
				depth_nx   = 16'd0;
				comp_nz_nx = 1'b0;
				img_w_nx   = '0;
				img_h_nx   = '0;
				col_nx     = '0;
				row_nx     = '0;
				bip_nx     = 2'd0;
				pad_nx     = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FILE;
			cnt_q     <= 6'd0;
			sig_bad_q <= 1'b0;
			size_q    <= 32'd0;
			raw_w_q   <= 32'd0;
			raw_h_q   <= 32'd0;
			depth_q   <= 16'd0;
			comp_nz_q <= 1'b0;
			img_w_q   <= '0;
			img_h_q   <= '0;
			col_q     <= '0;
			row_q     <= '0;
			bip_q     <= 2'd0;
			pad_q     <= 2'd0;
		end else begin
			phase_q   <= phase_nx;
			cnt_q     <= cnt_nx;
			sig_bad_q <= sig_bad_nx;
			size_q    <= size_nx;
			raw_w_q   <= raw_w_nx;
			raw_h_q   <= raw_h_nx;
			depth_q   <= depth_nx;
			comp_nz_q <= comp_nz_nx;
			img_w_q   <= img_w_nx;
			img_h_q   <= img_h_nx;
			col_q     <= col_nx;
			row_q     <= row_nx;
			bip_q     <= bip_nx;
			pad_q     <= pad_nx;
		end
	end

endmodule

`default_nettype wire

// ===== src/bmpdec_fifo.sv =====
// Short token queue between the front end and the back end.
// Depends on bmpdec_pkg for the token type.
`default_nettype none

module bmpdec_fifo import bmpdec_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire token_t wdata,
	output logic        full,
	input  wire logic   pop,
	output token_t      rdata,
	output logic        empty
);

	localparam int PTR_W = (DEPTH < 2) ? 1 : $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	token_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== src/bmpdec_back.sv =====
// Back end: gathers the colour bytes of each pixel and holds the result register.
// Depends on bmpdec_pkg for token and result types.
`default_nettype none

module bmpdec_back import bmpdec_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   tok_empty,
	input  wire token_t tok,
	output logic        tok_take,
	output out_item_t   result,
	output logic        empty,
	input  wire logic   pop
);

	logic [15:0] held_bg_q;
	out_item_t   out_q;
	out_item_t   pix_item;
	logic        out_vld_q;
	logic        gives_item, slot_free;

	assign gives_item = (tok.op == TOK_ITEM) || (tok.op == TOK_RED);
	assign slot_free  = !out_vld_q || pop;
	// blue and green bytes never need the output slot
	assign tok_take   = !tok_empty && (!gives_item || slot_free);
	assign result     = out_q;
	assign empty      = !out_vld_q;

	// merge the red byte with the held blue and green bytes
	always_comb begin
		pix_item       = tok.item;
		pix_item.red   = tok.data_byte;
		pix_item.green = held_bg_q[15:8];
		pix_item.blue  = held_bg_q[7:0];
	end

	always_ff @(posedge clk) begin
		if (tok_take) begin
			unique case (tok.op)
				TOK_BLUE:  held_bg_q[7:0]  <= tok.data_byte;
				TOK_GREEN: held_bg_q[15:8] <= tok.data_byte;
				TOK_ITEM:  out_q           <= tok.item;
				TOK_RED:   out_q           <= pix_item;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (tok_take && gives_item)
			out_vld_q <= 1'b1;
		else if (pop)
			out_vld_q <= 1'b0;
	end

endmodule

`default_nettype wire

// ===== src/bmp_rgb24_stream_decoder.sv =====
// Bitmap 24-bit decoder: one file byte per transfer, one byte per cycle while the
// token queue has room. A result passes through the token queue and then the output
// register before it shows on the result ports. Throughput is set by the front
// parser and the back end, each one token a cycle while neither is held back.
// Reset (arst_n low, asynchronous) returns the parser to the file header,
// empties the token queue and drops any result held in the output register.
// Depends on bmpdec_pkg, bmpdec_front, bmpdec_fifo and bmpdec_back.
`default_nettype none

module bmp_rgb24_stream_decoder import bmpdec_pkg::*; #(
	parameter int MAX_DIM     = MAX_DIM_DEFAULT,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t feed,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	logic   accept;
	logic   tok_valid;
	token_t tok_w;
	token_t tok_r;
	logic   q_empty;
	logic   tok_take;

	// A byte transfers whenever the queue has room; the front never stalls otherwise.
	assign accept = push && !full;

	// Front: parse headers, track pixel position, classify each byte into a token.
	bmpdec_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.feed      (feed),
		.tok_valid (tok_valid),
		.tok       (tok_w)
	);

	// Queue: decouple the parser from result back-pressure.
	bmpdec_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_valid),
		.wdata  (tok_w),
		.full   (full),
		.pop    (tok_take),
		.rdata  (tok_r),
		.empty  (q_empty)
	);

	// Back: assemble RGB pixels and hold the oldest result until popped.
	bmpdec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (q_empty),
		.tok       (tok_r),
		.tok_take  (tok_take),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire
